// ===== hdl/compacting_ordered_list_macros.svh =====
// ----------------------------------------------------------------------------
// Compacting ordered list assertion macros
// Shared concurrent assertion forms used by the list RTL.
// ----------------------------------------------------------------------------
`ifndef COMPACTING_ORDERED_LIST_MACROS_SVH
`define COMPACTING_ORDERED_LIST_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define COL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define COL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/col_pkg.sv =====
// ----------------------------------------------------------------------------
// Compacting ordered list package
// Command and status codes, port widths and the cell control bundle.
// ----------------------------------------------------------------------------
package col_pkg;

   localparam int COL_CAPACITY    = 64;
   localparam int COL_VALUE_WIDTH = 32;

   localparam int COL_CMD_W    = 3;
   localparam int COL_POS_W    = 6;
   localparam int COL_ITEM_W   = 32;
   localparam int COL_STATUS_W = 2;
   localparam int COL_COUNT_W  = 7;

   typedef enum logic [COL_CMD_W-1:0] {
      CMD_APPEND     = 3'd0,
      CMD_REMOVE_AT  = 3'd1,
      CMD_REMOVE_VAL = 3'd2,
      CMD_READ       = 3'd3,
      CMD_CLEAR      = 3'd4
   } cmd_type;

   typedef enum logic [COL_STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_RANGE     = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   // Per-cycle operation broadcast to every cell in the row.
   typedef struct packed {
      logic append;
      logic remove_at;
      logic remove_val;
   } cell_ctl_type;

endpackage

// ===== hdl/col_cell.sv =====
// ----------------------------------------------------------------------------
// Compacting ordered list cell
// Holds one list entry, matches it against the search key and takes its
// upper neighbor's entry when an entry at or below it is removed.
// ----------------------------------------------------------------------------
module col_cell import col_pkg::*; #(
   parameter int VALUE_WIDTH = COL_VALUE_WIDTH,
   parameter int CNT_W       = 7,
   parameter int POS_W       = 7,
   parameter int INDEX       = 0
) (
   input  logic                   clock,
   input  cell_ctl_type           ctl,
   input  logic [VALUE_WIDTH-1:0] key,
   input  logic [CNT_W-1:0]       count,
   input  logic [POS_W-1:0]       position,
   input  logic [VALUE_WIDTH-1:0] upper_value,
   input  logic                   hit_in,
   output logic [VALUE_WIDTH-1:0] entry_value,
   output logic [VALUE_WIDTH-1:0] read_value,
   output logic                   hit_out
);

   logic [VALUE_WIDTH-1:0] entry_ff;
   logic [VALUE_WIDTH-1:0] entry_in;
   logic                   occupied;
   logic                   match;

   always_comb begin
      occupied = count > CNT_W'(INDEX);
      match    = occupied && (entry_ff == key);
      // The hit ripples upward: every cell above the first match shifts down.
      hit_out  = hit_in | match;

      entry_in = entry_ff;
      priority if (ctl.append && (count == CNT_W'(INDEX))) begin
         entry_in = key;
      end else if (ctl.remove_at && (position <= POS_W'(INDEX))) begin
         entry_in = upper_value;
      end else if (ctl.remove_val && hit_out) begin
         entry_in = upper_value;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_value = entry_ff;
   assign read_value  = (position == POS_W'(INDEX)) ? entry_ff : '0;

endmodule

// ===== hdl/compacting_ordered_list.sv =====
// ----------------------------------------------------------------------------
// Compacting ordered list
// An ordered list of up to CAPACITY values held in a row of cells, with
// append, remove at index, remove by value, read at index and clear.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                                         Direction
//  -------   --------------------------------------------  ---------
//  request   req_valid, req_stall, req_cmd, req_position,   in
//            req_item_value
//  response  rsp_valid, rsp_stall, rsp_status,              out
//            rsp_read_value, rsp_entry_count
//
// All cells compare and shift in parallel for each command, so a new request
// transfer can happen on every clock edge while req_stall is low. The response
// appears in the output register in the cycle after its request transfer.
// Reset is synchronous and active high; it empties the list (count to zero)
// and drops any waiting response. Entry contents are not cleared.
// A stalled response holds the request side off only while the output
// register is full and not being taken in the same cycle.
//
module compacting_ordered_list import col_pkg::*; #(
   parameter int CAPACITY    = COL_CAPACITY,
   parameter int VALUE_WIDTH = COL_VALUE_WIDTH
) (
   input  logic                    clock,
   input  logic                    reset,

   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [COL_CMD_W-1:0]    req_cmd,
   input  logic [COL_POS_W-1:0]    req_position,
   input  logic [COL_ITEM_W-1:0]   req_item_value,

   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [COL_STATUS_W-1:0] rsp_status,
   output logic [COL_ITEM_W-1:0]   rsp_read_value,
   output logic [COL_COUNT_W-1:0]  rsp_entry_count
);

`include "compacting_ordered_list_macros.svh"

   // Count holds 0..CAPACITY; the index compare width covers both the
   // request position and every cell index.
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int POS_W = (CNT_W > COL_POS_W) ? CNT_W : COL_POS_W;

   logic [CNT_W-1:0]        count_ff;
   logic [CNT_W-1:0]        count_in;

   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   status_type              rsp_status_ff;
   status_type              rsp_status_in;
   logic [COL_ITEM_W-1:0]   rsp_read_value_ff;
   logic [COL_ITEM_W-1:0]   rsp_read_value_in;
   logic [COL_COUNT_W-1:0]  rsp_entry_count_ff;

   logic                    accept;
   cmd_type                 cmd;
   logic [VALUE_WIDTH-1:0]  key;
   logic [POS_W-1:0]        pos_wide;
   logic                    full;
   logic                    in_range;
   logic                    found;
   cell_ctl_type            ctl;
   logic [VALUE_WIDTH-1:0]  read_any;

   logic [VALUE_WIDTH-1:0]  cell_value [CAPACITY];
   logic [VALUE_WIDTH-1:0]  cell_upper [CAPACITY];
   logic [VALUE_WIDTH-1:0]  cell_read  [CAPACITY];
   logic                    hit_chain  [CAPACITY+1];

   // A new request transfer is blocked only by a waiting response that is
   // not being taken in this cycle.
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   assign cmd      = cmd_type'(req_cmd);
   // Stored values are cut (or zero-extended) to VALUE_WIDTH, and so is the
   // search key, so that compares match what was appended.
   assign key      = VALUE_WIDTH'(req_item_value);
   assign pos_wide = POS_W'(req_position);
   assign full     = count_ff == CNT_W'(CAPACITY);
   assign in_range = pos_wide < POS_W'(count_ff);

   // Cell operations. Remove by value is broadcast unconditionally; only the
   // cells at or above the first match actually shift.
   always_comb begin
      ctl.append     = accept && (cmd == CMD_APPEND) && !full;
      ctl.remove_at  = accept && (cmd == CMD_REMOVE_AT) && in_range;
      ctl.remove_val = accept && (cmd == CMD_REMOVE_VAL);
   end

   assign hit_chain[0] = 1'b0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      // The top cell has no upper neighbor and simply keeps its entry.
      if (i == CAPACITY - 1) begin : g_top
         assign cell_upper[i] = cell_value[i];
      end else begin : g_mid
         assign cell_upper[i] = cell_value[i+1];
      end

      col_cell #(
         .VALUE_WIDTH (VALUE_WIDTH),
         .CNT_W       (CNT_W),
         .POS_W       (POS_W),
         .INDEX       (i)
      ) u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .key         (key),
         .count       (count_ff),
         .position    (pos_wide),
         .upper_value (cell_upper[i]),
         .hit_in      (hit_chain[i]),
         .entry_value (cell_value[i]),
         .read_value  (cell_read[i]),
         .hit_out     (hit_chain[i+1])
      );
   end

   assign found = hit_chain[CAPACITY];

   // Only the addressed cell drives a nonzero read value, so an OR over the
   // row picks it out.
   always_comb begin
      read_any = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         read_any = read_any | cell_read[i];
      end
   end

   // Next count and response contents for the command being transferred.
   always_comb begin
      count_in          = count_ff;
      rsp_status_in     = ST_OK;
      rsp_read_value_in = '0;
      unique case (cmd)
         CMD_APPEND: begin
            if (full) begin
               rsp_status_in = ST_FULL;
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         CMD_REMOVE_AT: begin
            if (in_range) begin
               count_in = count_ff - CNT_W'(1);
            end else begin
               rsp_status_in = ST_RANGE;
            end
         end
         CMD_REMOVE_VAL: begin
            if (found) begin
               count_in = count_ff - CNT_W'(1);
            end else begin
               rsp_status_in = ST_NOT_FOUND;
            end
         end
         CMD_READ: begin
            if (in_range) begin
               rsp_read_value_in = COL_ITEM_W'(read_any);
            end else begin
               rsp_status_in = ST_RANGE;
            end
         end
         CMD_CLEAR: begin
            count_in = '0;
         end
         default: begin
            // Unused command codes leave the list untouched and report ok.
         end
      endcase
   end

   assign rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   // Response payload needs no reset; it loads on every request transfer.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff      <= rsp_status_in;
         rsp_read_value_ff  <= rsp_read_value_in;
         rsp_entry_count_ff <= COL_COUNT_W'(count_in);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_read_value  = rsp_read_value_ff;
   assign rsp_entry_count = rsp_entry_count_ff;

   // The count never grows past the number of cells.
   `COL_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(CAPACITY), "count above capacity")

   // Clear empties the list on the next cycle.
   `COL_ASSERT_NEXT(a_clear_empties, clock, reset, accept && (cmd == CMD_CLEAR), count_ff == '0, "clear did not empty the list")

   // Append to a full list reports full and leaves the count alone.
   `COL_ASSERT_NEXT(a_full_drop, clock, reset, accept && (cmd == CMD_APPEND) && full, (rsp_status_ff == ST_FULL) && (count_ff == $past(count_ff)), "append to full list mishandled")

   // A response that is taken with no new request transfer leaves the register empty.
   `COL_ASSERT_NEXT(a_rsp_drain, clock, reset, rsp_valid_ff && !rsp_stall && !accept, !rsp_valid_ff, "response not drained")

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Compacting ordered list testbench
// Drives list commands through the request channel with random gaps, takes
// responses with random stalls and compares each response with the result
// of a list predictor kept inside the bench.
// ----------------------------------------------------------------------------
module tb;
   import col_pkg::*;

   // Command codes that the block does not decode. They must leave the list
   // alone and still give one response.
   localparam logic [COL_CMD_W-1:0] CMD_SPARE_LO = 3'd5;
   localparam logic [COL_CMD_W-1:0] CMD_SPARE_HI = 3'd7;

   // Cycles without any transfer on either channel before the run is declared
   // hung. The long receiver hold-off is far below this.
   localparam int IDLE_LIMIT   = 4000;
   localparam int HOLD_CYCLES  = 250;
   localparam int HOLD_AT      = 400;
   localparam int RANDOM_ITEMS = 1750;
   localparam int SHOWN_ERRORS = 40;

   // One queued command, with the number of idle cycles the sender spends
   // before offering it and whether it must wait until the list has drained.
   typedef struct {
      logic [COL_CMD_W-1:0]  cmd;
      logic [COL_POS_W-1:0]  pos;
      logic [COL_ITEM_W-1:0] value;
      int                    gap;
      bit                    drain;
   } list_cmd_type;

   // What a response must carry.
   typedef struct packed {
      status_type             status;
      logic [COL_ITEM_W-1:0]  read_value;
      logic [COL_COUNT_W-1:0] entry_count;
   } list_result_type;

   logic                    clock;
   logic                    reset           = 1'b1;
   logic                    req_valid       = 1'b0;
   logic                    req_stall;
   logic [COL_CMD_W-1:0]    req_cmd         = CMD_READ;
   logic [COL_POS_W-1:0]    req_position    = '0;
   logic [COL_ITEM_W-1:0]   req_item_value  = '0;
   logic                    rsp_valid;
   logic                    rsp_stall       = 1'b0;
   logic [COL_STATUS_W-1:0] rsp_status;
   logic [COL_ITEM_W-1:0]   rsp_read_value;
   logic [COL_COUNT_W-1:0]  rsp_entry_count;

   // Commands not yet offered, and responses owed for commands already taken.
   list_cmd_type    pending_cmds[$];
   list_result_type awaited_results[$];

   // Shadow of the list contents as the generator sees it. It only steers
   // the stimulus (valid indexes, values that are present) and checks nothing.
   logic [COL_ITEM_W-1:0] gen_shadow[$];

   // Predictor state: the entries and how many of them are live.
   logic [COL_ITEM_W-1:0] kept[COL_CAPACITY];
   int                    kept_count = 0;

   int errors         = 0;
   int requests_taken = 0;
   int results_seen   = 0;
   int gap_left       = -1;
   int rx_wait        = 0;
   int hold_left      = 0;
   bit hold_done      = 1'b0;
   int idle_cycles    = 0;

   compacting_ordered_list dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_position    (req_position),
      .req_item_value  (req_item_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_read_value  (rsp_read_value),
      .rsp_entry_count (rsp_entry_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Delete the entry at idx and slide every later entry down one place.
   function automatic void close_gap(input int idx);
      for (int i = idx; i + 1 < kept_count; i++) kept[i] = kept[i + 1];
      kept_count--;
   endfunction

   // Apply one command to the predicted list and return the response it owes.
   function automatic list_result_type apply_command(input logic [COL_CMD_W-1:0] cmd,
                                                     input logic [COL_POS_W-1:0] pos,
                                                     input logic [COL_ITEM_W-1:0] value);
      list_result_type r;
      int              hit;
      r.status     = ST_OK;
      r.read_value = '0;
      hit          = -1;
      case (cmd)
         CMD_APPEND: begin
            if (kept_count >= COL_CAPACITY) begin
               r.status = ST_FULL;
            end else begin
               kept[kept_count] = value;
               kept_count++;
            end
         end
         CMD_REMOVE_AT: begin
            if (int'(pos) >= kept_count) r.status = ST_RANGE;
            else close_gap(int'(pos));
         end
         CMD_REMOVE_VAL: begin
            for (int i = 0; i < kept_count; i++) begin
               if (hit < 0 && kept[i] == value) hit = i;
            end
            if (hit < 0) r.status = ST_NOT_FOUND;
            else close_gap(hit);
         end
         CMD_READ: begin
            if (int'(pos) >= kept_count) r.status = ST_RANGE;
            else r.read_value = kept[pos];
         end
         CMD_CLEAR: begin
            kept_count = 0;
         end
         default: begin
         end
      endcase
      r.entry_count = COL_COUNT_W'(kept_count);
      return r;
   endfunction

   // Queue one command and keep the generator's shadow of the list in step.
   // The sender runs without gaps for one block of 150 commands in three.
   function automatic void add_cmd(input logic [COL_CMD_W-1:0] cmd,
                                   input logic [COL_POS_W-1:0] pos,
                                   input logic [COL_ITEM_W-1:0] value,
                                   input bit drain);
      list_cmd_type c;
      int           hit;
      hit     = -1;
      c.cmd   = cmd;
      c.pos   = pos;
      c.value = value;
      c.drain = drain;
      c.gap   = (((pending_cmds.size() / 150) % 3) == 1) ? 0 : $urandom_range(0, 9);
      pending_cmds.push_back(c);
      case (cmd)
         CMD_APPEND: begin
            if (gen_shadow.size() < COL_CAPACITY) gen_shadow.push_back(value);
         end
         CMD_REMOVE_AT: begin
            if (int'(pos) < gen_shadow.size()) gen_shadow.delete(int'(pos));
         end
         CMD_REMOVE_VAL: begin
            foreach (gen_shadow[i]) begin
               if (hit < 0 && gen_shadow[i] == value) hit = i;
            end
            if (hit >= 0) gen_shadow.delete(hit);
         end
         CMD_CLEAR: begin
            gen_shadow.delete();
         end
         default: begin
         end
      endcase
   endfunction

   // Mostly a live index, sometimes the first index past the end, sometimes
   // anything the field can hold.
   function automatic logic [COL_POS_W-1:0] pick_position();
      int n;
      n = gen_shadow.size();
      if (n == 0 || $urandom_range(0, 5) == 0) return COL_POS_W'($urandom_range(0, 63));
      if ($urandom_range(0, 7) == 0 && n < COL_CAPACITY) return COL_POS_W'(n);
      return COL_POS_W'($urandom_range(0, n - 1));
   endfunction

   // Small values repeat often, which exercises the first-match rule of
   // remove by value; full-width values toggle every bit.
   function automatic logic [COL_ITEM_W-1:0] new_value();
      if ($urandom_range(0, 2) == 0) return COL_ITEM_W'($urandom_range(0, 7));
      return $urandom();
   endfunction

   // A value to search for: usually one that is held, else a fresh one.
   function automatic logic [COL_ITEM_W-1:0] search_value();
      if (gen_shadow.size() != 0 && $urandom_range(0, 9) < 7)
         return gen_shadow[$urandom_range(0, gen_shadow.size() - 1)];
      return new_value();
   endfunction

   task automatic report_mismatch(input string field, input logic [COL_ITEM_W-1:0] got,
                                  input logic [COL_ITEM_W-1:0] want);
      errors++;
      if (errors <= SHOWN_ERRORS)
         $display("mismatch on %s at response %0d: got %h, want %h",
                  field, results_seen, got, want);
   endtask

   // Sender. A command is moved from the pending queue onto the request ports
   // once its gap has run out; a command marked for draining also waits until
   // every owed response has come back. The prediction is made at the edge
   // where the transfer happens, so it follows the order the block sees.
   always @(posedge clock) begin : sender
      logic         offer;
      list_cmd_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = -1;
      end else begin
         offer = req_valid;
         if (req_valid && !req_stall) begin
            awaited_results.push_back(apply_command(req_cmd, req_position, req_item_value));
            requests_taken++;
            offer = 1'b0;
         end
         if (!offer && pending_cmds.size() != 0) begin
            if (gap_left < 0) gap_left = pending_cmds[0].gap;
            if (gap_left > 0) begin
               gap_left--;
            end else if (!pending_cmds[0].drain || awaited_results.size() == 0) begin
               nxt = pending_cmds.pop_front();
               gap_left = -1;
               req_cmd        <= nxt.cmd;
               req_position   <= nxt.pos;
               req_item_value <= nxt.value;
               offer = 1'b1;
            end
         end
         // One assignment per edge, so a valid that stays high never dips.
         req_valid <= offer;
      end
   end

   // Receiver. Every response transfer is checked against the oldest owed
   // result, then a fresh stall length is drawn. One block of responses in
   // three is taken without stalls, and once, part way through, the receiver
   // holds off for a long stretch so that the output register fills and the
   // block pushes back on the request side.
   always @(posedge clock) begin : receiver
      list_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         rx_wait = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (awaited_results.size() == 0) begin
               report_mismatch("unrequested response", rsp_read_value, '0);
            end else begin
               want = awaited_results.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch("status", COL_ITEM_W'(rsp_status), COL_ITEM_W'(want.status));
               if (rsp_read_value !== want.read_value)
                  report_mismatch("read_value", rsp_read_value, want.read_value);
               if (rsp_entry_count !== want.entry_count)
                  report_mismatch("entry_count", COL_ITEM_W'(rsp_entry_count),
                                  COL_ITEM_W'(want.entry_count));
            end
            rx_wait = (((results_seen / 130) % 3) == 2) ? 0 : $urandom_range(0, 9);
         end else if (rx_wait > 0) begin
            rx_wait--;
         end
         if (!hold_done && requests_taken >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= (rx_wait != 0);
         end
      end
   end

   // Watchdog: any transfer on either channel resets the count.
   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int  n;
      int  roll;
      bit  drain;
      logic [COL_ITEM_W-1:0] v;

      // Directed part. Empty-list errors first, then the unused codes.
      add_cmd(CMD_READ, '0, '0, 1'b0);
      add_cmd(CMD_REMOVE_AT, '1, '0, 1'b0);
      add_cmd(CMD_REMOVE_VAL, '0, '1, 1'b0);
      for (int c = CMD_SPARE_LO; c <= CMD_SPARE_HI; c++)
         add_cmd(COL_CMD_W'(c), '1, '1, 1'b0);

      // A short list with a repeated zero, so remove by value must take the
      // first match and leave the second.
      add_cmd(CMD_APPEND, '0, '1, 1'b0);
      add_cmd(CMD_APPEND, '1, '0, 1'b0);
      add_cmd(CMD_APPEND, '0, 32'hA5A5_5A5A, 1'b0);
      add_cmd(CMD_APPEND, '0, '0, 1'b0);
      add_cmd(CMD_APPEND, '0, 32'h0000_0001, 1'b0);
      add_cmd(CMD_READ, '0, '0, 1'b0);
      add_cmd(CMD_READ, 6'd4, '0, 1'b0);
      add_cmd(CMD_READ, 6'd5, '0, 1'b0);
      add_cmd(CMD_READ, '1, '0, 1'b0);
      add_cmd(CMD_REMOVE_VAL, '0, '0, 1'b0);
      add_cmd(CMD_READ, 6'd1, '0, 1'b0);

      // Remove the last entry and the first one, miss a search, then clear
      // and make sure nothing is readable or removable afterwards.
      add_cmd(CMD_REMOVE_AT, 6'd3, '0, 1'b0);
      add_cmd(CMD_REMOVE_AT, '0, '0, 1'b0);
      add_cmd(CMD_REMOVE_VAL, '0, 32'h1234_5678, 1'b0);
      add_cmd(CMD_CLEAR, '1, '1, 1'b0);
      add_cmd(CMD_READ, '0, '0, 1'b0);
      add_cmd(CMD_REMOVE_VAL, '0, '0, 1'b0);

      // Random part, in episodes. A fill episode appends until the list is
      // full and then a few more to hit the full case; a mixed episode mixes
      // appends, reads, removals, clears and unused codes on whatever the list
      // holds. Now and then an episode starts only after the block has drained.
      drain = 1'b1;
      while (pending_cmds.size() < RANDOM_ITEMS) begin
         roll = $urandom_range(0, 9);
         if (roll < 3) begin
            n = COL_CAPACITY - gen_shadow.size() + $urandom_range(1, 3);
            for (int k = 0; k < n; k++)
               add_cmd(CMD_APPEND, pick_position(), new_value(), drain && k == 0);
         end else begin
            n = $urandom_range(20, 40);
            for (int k = 0; k < n; k++) begin
               roll = $urandom_range(0, 99);
               if (roll < 32) begin
                  add_cmd(CMD_APPEND, pick_position(), new_value(), drain && k == 0);
               end else if (roll < 57) begin
                  add_cmd(CMD_READ, pick_position(), new_value(), drain && k == 0);
               end else if (roll < 72) begin
                  add_cmd(CMD_REMOVE_AT, pick_position(), new_value(), drain && k == 0);
               end else if (roll < 95) begin
                  v = search_value();
                  add_cmd(CMD_REMOVE_VAL, pick_position(), v, drain && k == 0);
               end else if (roll < 97) begin
                  add_cmd(CMD_CLEAR, pick_position(), new_value(), drain && k == 0);
               end else begin
                  add_cmd(COL_CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)),
                          pick_position(), new_value(), drain && k == 0);
               end
            end
         end
         drain = ($urandom_range(0, 7) == 0);
      end

      // Reset is held from the start and released once.
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Wait for the last command to be taken and its response checked, then
      // give the block a few cycles to show any stray response.
      while (pending_cmds.size() != 0 || req_valid || awaited_results.size() != 0)
         @(posedge clock);
      repeat (16) @(posedge clock);

      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/col_pkg.sv
hdl/col_cell.sv
hdl/compacting_ordered_list.sv
test/tb.sv
